FILE: hw/rtl/lru_page_replacement_unit_assert.svh
// assertion macros for the lru page replacement unit
// no dependencies; included by the rtl file that checks its own logic
`ifndef LRU_PAGE_REPLACEMENT_UNIT_ASSERT_SVH
`define LRU_PAGE_REPLACEMENT_UNIT_ASSERT_SVH

// same-cycle implication, disabled during reset
`define LRUPR_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("lrupr assertion failed");

// next-cycle implication, disabled during reset
`define LRUPR_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("lrupr assertion failed");

`endif

FILE: hw/rtl/lrupr_pkg.sv
// shared types, constants and helpers of the lru page replacement unit
// no dependencies
package lrupr_pkg;

  localparam int unsigned MaxFramesDef = 32;
  localparam int unsigned PageBitsDef  = 16;
  localparam int unsigned FramesW      = 6;
  localparam int unsigned FaultW       = 16;
  localparam int unsigned ClampW       = 7;

  localparam logic [FramesW-1:0] FramesReset = FramesW'(4);
  localparam logic [FaultW-1:0]  FaultMax    = {FaultW{1'b1}};

  typedef struct packed {
    logic accept;
    logic valid;
    logic pass;
  } cell_ctrl_t;

  typedef struct packed {
    logic match;
    logic pass;
  } cell_stat_t;

  // zero frames means one, anything above the table depth means the depth
  function automatic logic [ClampW-1:0] clamp_frames(input logic [FramesW-1:0] v,
                                                     input int unsigned max_frames);
    logic [ClampW-1:0] ext;
    logic [ClampW-1:0] lim;
    ext = ClampW'(v);
    lim = ClampW'(max_frames);
    if (ext == '0) begin
      clamp_frames = ClampW'(1);
    end else if (ext > lim) begin
      clamp_frames = lim;
    end else begin
      clamp_frames = ext;
    end
  endfunction

endpackage

FILE: hw/rtl/lru_page_replacement_unit.sv
// lru page replacement unit: recency chain of cells, most recent page in cell 0
// depends on lrupr_pkg, lrupr_cell and lru_page_replacement_unit_assert.svh
//
// channel   direction  handshake                 payload
// in        in         in_valid_i / in_stall_o   page_number_i, start_trace_i
// out       out        out_valid_o / out_stall_i hit_o, evicted_valid_o, evicted_page_o,
//                                                fault_count_o
// cfg       in         cfg_we_i                  cfg_wdata_i (frames_in_use)
//
// one word per cycle while in_stall_o is low: every cell compares in parallel and shifts in the same cycle
// a result word appears in the cycle after its reference is accepted
// in_stall_o rises only while a result word is held by out_stall_i
// reset empties the table, clears the fault count and sets frames_in_use to 4
// frames_in_use takes effect at reset and at each reference with start_trace_i set
`include "lru_page_replacement_unit_assert.svh"

module lru_page_replacement_unit #(
  parameter int unsigned MAX_FRAMES = lrupr_pkg::MaxFramesDef,
  parameter int unsigned PAGE_BITS  = lrupr_pkg::PageBitsDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [lrupr_pkg::FramesW-1:0]   cfg_wdata_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [PAGE_BITS-1:0]            page_number_i,
  input  logic                            start_trace_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic                            hit_o,
  output logic                            evicted_valid_o,
  output logic [PAGE_BITS-1:0]            evicted_page_o,
  output logic [lrupr_pkg::FaultW-1:0]    fault_count_o
);
  import lrupr_pkg::*;

  localparam int unsigned CW = $clog2(MAX_FRAMES + 1);

  logic [FramesW-1:0]   frames_q;
  logic [CW-1:0]        active_q, active_d;
  logic [CW-1:0]        count_q, count_d;
  logic [FaultW-1:0]    fault_q, fault_d;
  logic                 out_valid_q, out_valid_d;
  logic                 hit_q, evict_q;
  logic [PAGE_BITS-1:0] victim_q;

  logic                 accept;
  logic [CW-1:0]        cur_count;
  logic [FaultW-1:0]    cur_fault;
  logic                 hit;
  logic                 evict;
  logic [PAGE_BITS-1:0] victim;

  logic [MAX_FRAMES-1:0] valid;
  logic [MAX_FRAMES-1:0] match;
  logic [MAX_FRAMES:0]   pass;
  logic [PAGE_BITS-1:0]  cell_page [MAX_FRAMES];

  assign accept     = in_valid_i && !in_stall_o;
  assign in_stall_o = out_valid_q && out_stall_i;

  assign cur_count = start_trace_i ? '0 : count_q;
  assign cur_fault = start_trace_i ? '0 : fault_q;
  assign active_d  = start_trace_i ? CW'(clamp_frames(frames_q, MAX_FRAMES)) : active_q;

  assign pass[0] = 1'b1;

  for (genvar k = 0; k < MAX_FRAMES; k++) begin : g_cell
    localparam logic [CW-1:0] Idx = CW'(k);
    cell_ctrl_t           ctrl;
    cell_stat_t           stat;
    logic [PAGE_BITS-1:0] prev_page;

    assign valid[k]    = Idx < cur_count;
    assign ctrl.accept = accept;
    assign ctrl.valid  = valid[k];
    assign ctrl.pass   = pass[k];

    if (k == 0) begin : g_head
      assign prev_page = page_number_i;
    end else begin : g_body
      assign prev_page = cell_page[k-1];
    end

    lrupr_cell #(
      .PAGE_BITS(PAGE_BITS)
    ) u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (ctrl),
      .page_i     (page_number_i),
      .prev_page_i(prev_page),
      .page_o     (cell_page[k]),
      .stat_o     (stat)
    );

    assign match[k]  = stat.match;
    assign pass[k+1] = stat.pass;
  end

  assign hit   = |match;
  assign evict = !hit && (cur_count >= active_d);

  // least recent page sits in the last valid cell
  always_comb begin
    victim = '0;
    for (int k = 0; k < MAX_FRAMES; k++) begin
      if (valid[k] && (k == MAX_FRAMES - 1 || !valid[(k + 1) % MAX_FRAMES])) begin
        victim = victim | cell_page[k];
      end
    end
  end

  assign count_d = (hit || evict) ? cur_count : cur_count + CW'(1);

  always_comb begin
    fault_d = cur_fault;
    if (!hit && cur_fault != FaultMax) begin
      fault_d = cur_fault + FaultW'(1);
    end
  end

  assign out_valid_d = accept ? 1'b1 : (out_stall_i ? out_valid_q : 1'b0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frames_q    <= FramesReset;
      active_q    <= CW'(clamp_frames(FramesReset, MAX_FRAMES));
      count_q     <= '0;
      fault_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        frames_q <= cfg_wdata_i;
      end
      if (accept) begin
        active_q <= active_d;
        count_q  <= count_d;
        fault_q  <= fault_d;
      end
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      hit_q    <= hit;
      evict_q  <= evict;
      victim_q <= evict ? victim : '0;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign hit_o           = hit_q;
  assign evicted_valid_o = evict_q;
  assign evicted_page_o  = victim_q;
  assign fault_count_o   = fault_q;

  `LRUPR_ASSERT_IMP(a_count_in_range, clk_i, rst_ni, 1'b1, count_q <= active_q)
  `LRUPR_ASSERT_IMP(a_single_match, clk_i, rst_ni, 1'b1, $onehot0(match))
  `LRUPR_ASSERT_IMP(a_evict_on_miss, clk_i, rst_ni, out_valid_q && evict_q, !hit_q)
  `LRUPR_ASSERT_NXT(a_hit_keeps_count, clk_i, rst_ni, accept && hit,
                    count_q == $past(cur_count))
  `LRUPR_ASSERT_NXT(a_miss_counts, clk_i, rst_ni, accept && !hit, fault_q != '0)

endmodule

FILE: hw/rtl/lrupr_cell.sv
// one recency cell: holds a page, compares it to the lookup, takes its neighbor's page
// depends on lrupr_pkg
module lrupr_cell #(
  parameter int unsigned PAGE_BITS = lrupr_pkg::PageBitsDef
) (
  input  logic                    clk_i,
  input  lrupr_pkg::cell_ctrl_t   ctrl_i,
  input  logic [PAGE_BITS-1:0]    page_i,
  input  logic [PAGE_BITS-1:0]    prev_page_i,
  output logic [PAGE_BITS-1:0]    page_o,
  output lrupr_pkg::cell_stat_t   stat_o
);
  import lrupr_pkg::*;

  logic [PAGE_BITS-1:0] page_q;
  logic                 match;

  assign match       = ctrl_i.valid && (page_q == page_i);
  assign page_o      = page_q;
  assign stat_o.match = match;
  assign stat_o.pass  = ctrl_i.pass && !match;

  // cells up to and including the hit, or all cells on a miss, shift one place toward the old end
  always_ff @(posedge clk_i) begin
    if (ctrl_i.accept && ctrl_i.pass) begin
      page_q <= prev_page_i;
    end
  end

endmodule

FILE: sim/tb_lru_page_replacement_unit.sv
// self-checking testbench for lru_page_replacement_unit: directed and random page traces
// depends on lrupr_pkg and the rtl of lru_page_replacement_unit; a queue-based lru predictor
// supplies the expected result word of every accepted reference
`timescale 1ns / 100ps

module tb_lru_page_replacement_unit;

  import lrupr_pkg::*;

  localparam int MaxFrames  = 32;
  localparam int PageBits   = 16;
  localparam int CycleLimit = 1_200_000;
  localparam int ReportCap  = 60;

  typedef struct packed {
    logic                hit;
    logic                evicted;
    logic [PageBits-1:0] victim;
    logic [FaultW-1:0]   faults;
  } lru_word_t;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [FramesW-1:0]  cfg_wdata_i;
  logic                in_valid_i;
  logic                in_stall_o;
  logic [PageBits-1:0] page_number_i;
  logic                start_trace_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic                hit_o;
  logic                evicted_valid_o;
  logic [PageBits-1:0] evicted_page_o;
  logic [FaultW-1:0]   fault_count_o;

  logic [FramesW-1:0]  frames_reg;
  int                  active_frames;
  logic [PageBits-1:0] recency_q[$];
  logic [FaultW-1:0]   fault_total;
  lru_word_t           pending_results[$];
  lru_word_t           check_word;

  bit sender_idle;
  bit recv_idle;
  int recv_hold;
  int cycle_count;
  int mismatches;
  int refs_sent;
  int words_checked;
  int traces_started;
  int hits_seen;
  int evictions_seen;

  lru_page_replacement_unit #(
    .MAX_FRAMES(MaxFrames),
    .PAGE_BITS (PageBits)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .page_number_i  (page_number_i),
    .start_trace_i  (start_trace_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .hit_o          (hit_o),
    .evicted_valid_o(evicted_valid_o),
    .evicted_page_o (evicted_page_o),
    .fault_count_o  (fault_count_o)
  );

  always #6 clk_i = ~clk_i;

  function automatic int frames_limit(input logic [FramesW-1:0] v);
    if (v == '0) begin
      return 1;
    end
    if (int'(v) > MaxFrames) begin
      return MaxFrames;
    end
    return int'(v);
  endfunction

  function automatic lru_word_t lru_predict(input logic [PageBits-1:0] page, input logic start);
    lru_word_t w;
    int        pos;
    w   = '0;
    pos = -1;
    if (start) begin
      recency_q.delete();
      fault_total   = '0;
      active_frames = frames_limit(frames_reg);
    end
    foreach (recency_q[i]) begin
      if (pos < 0 && recency_q[i] == page) begin
        pos = i;
      end
    end
    if (pos >= 0) begin
      w.hit = 1'b1;
      recency_q.delete(pos);
    end else begin
      if (fault_total != FaultMax) begin
        fault_total = fault_total + 1'b1;
      end
      if (recency_q.size() >= active_frames && recency_q.size() > 0) begin
        w.evicted = 1'b1;
        w.victim  = recency_q.pop_front();
      end
    end
    recency_q.push_back(page);
    w.faults = fault_total;
    return w;
  endfunction

  task automatic report_field(input string what, input logic [PageBits-1:0] want,
                              input logic [PageBits-1:0] got);
    mismatches++;
    if (mismatches <= ReportCap) begin
      $display("%0t ns: %s mismatch, expected %h, actual %h", $time, what, want, got);
    end
  endtask

  // result word checker
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      words_checked++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= ReportCap) begin
          $display("%0t ns: unexpected word, expected none, actual hit %b evict %b page %h faults %h",
                   $time, hit_o, evicted_valid_o, evicted_page_o, fault_count_o);
        end
      end else begin
        check_word = pending_results.pop_front();
        if (hit_o !== check_word.hit) begin
          report_field("hit", PageBits'(check_word.hit), PageBits'(hit_o));
        end
        if (evicted_valid_o !== check_word.evicted) begin
          report_field("evicted_valid", PageBits'(check_word.evicted), PageBits'(evicted_valid_o));
        end
        if (evicted_page_o !== check_word.victim) begin
          report_field("evicted_page", check_word.victim, evicted_page_o);
        end
        if (fault_count_o !== check_word.faults) begin
          report_field("fault_count", check_word.faults, fault_count_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  // receiver: per-word stall draw plus an optional long hold-off
  initial begin : receiver
    int n;
    out_stall_i = 1'b0;
    forever begin
      n         = recv_idle ? $urandom_range(0, 14) : 0;
      n         = n + recv_hold;
      recv_hold = 0;
      if (n > 0) begin
        out_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!(out_valid_o && !out_stall_i));
    end
  end

  task automatic send_ref(input logic [PageBits-1:0] page, input logic start);
    int        gap;
    lru_word_t w;
    gap = sender_idle ? $urandom_range(0, 14) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    page_number_i <= page;
    start_trace_i <= start;
    do @(posedge clk_i); while (in_stall_o);
    w = lru_predict(page, start);
    pending_results.push_back(w);
    refs_sent++;
    if (start) begin
      traces_started++;
    end
    if (w.hit) begin
      hits_seen++;
    end
    if (w.evicted) begin
      evictions_seen++;
    end
  endtask

  task automatic wait_all_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic set_frames(input logic [FramesW-1:0] v);
    wait_all_results();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    frames_reg  = v;
  endtask

  task automatic test_reset_defaults();
    sender_idle = 1'b1;
    recv_idle   = 1'b1;
    send_ref(16'h0000, 1'b0);
    send_ref(16'hffff, 1'b0);
    send_ref(16'h0000, 1'b0);
    send_ref(16'h5555, 1'b0);
    send_ref(16'haaaa, 1'b0);
    send_ref(16'h8001, 1'b0);
    send_ref(16'h0000, 1'b0);
    send_ref(16'h1234, 1'b0);
    send_ref(16'h1234, 1'b1);
    send_ref(16'h1234, 1'b0);
  endtask

  task automatic test_frame_clamp();
    set_frames(6'd0);
    send_ref(16'h0f0f, 1'b1);
    send_ref(16'hf0f0, 1'b0);
    send_ref(16'hf0f0, 1'b0);
    send_ref(16'h0f0f, 1'b0);
    set_frames(6'd63);
    send_ref(16'h0100, 1'b1);
    for (int i = 1; i < MaxFrames + 2; i++) begin
      send_ref(PageBits'(16'h0100 + i), 1'b0);
    end
  endtask

  task automatic test_mid_trace_config();
    set_frames(6'd2);
    send_ref(16'h00a1, 1'b1);
    send_ref(16'h00b2, 1'b0);
    set_frames(6'd1);
    send_ref(16'h00c3, 1'b0);
    send_ref(16'h00b2, 1'b0);
    send_ref(16'h00d4, 1'b1);
    send_ref(16'h00e5, 1'b0);
  endtask

  task automatic test_fault_count();
    sender_idle = 1'b0;
    recv_idle   = 1'b0;
    set_frames(6'd1);
    send_ref(16'h0000, 1'b1);
    for (int i = 1; i < 200; i++) begin
      send_ref(PageBits'(i), 1'b0);
    end
    send_ref(PageBits'(199), 1'b0);
    send_ref(16'h7777, 1'b0);
    send_ref(16'h7777, 1'b1);
  endtask

  task automatic test_random_traces(input int n_items);
    logic [PageBits-1:0] pool[0:39];
    logic [FramesW-1:0]  v;
    int                  sent;
    int                  seg_len;
    int                  pool_n;
    int                  lim;
    bit                  new_trace;
    bit                  hold_done;
    sent      = 0;
    hold_done = 1'b0;
    while (sent < n_items) begin
      case ($urandom_range(0, 9)) inside
        0: v = 6'd0;
        1: v = 6'd63;
        2: v = 6'd32;
        3: v = 6'd33;
        4: v = 6'd1;
        5, 6: v = FramesW'($urandom_range(2, 8));
        default: v = FramesW'($urandom_range(0, 63));
      endcase
      set_frames(v);
      new_trace   = ($urandom_range(0, 7) != 0);
      sender_idle = ($urandom_range(0, 2) != 0);
      recv_idle   = ($urandom_range(0, 2) != 0);
      if (!hold_done && sent > n_items / 2) begin
        sender_idle = 1'b0;
        recv_hold   = 90;
        hold_done   = 1'b1;
      end
      lim    = new_trace ? frames_limit(v) : active_frames;
      pool_n = $urandom_range(1, (lim + 4 > 40) ? 40 : lim + 4);
      for (int i = 0; i < 40; i++) begin
        pool[i] = PageBits'($urandom);
      end
      seg_len = $urandom_range(15, 90);
      for (int k = 0; k < seg_len; k++) begin
        send_ref(($urandom_range(0, 99) < 85) ? pool[$urandom_range(0, pool_n - 1)]
                                               : PageBits'($urandom),
                 (k == 0 && new_trace) || ($urandom_range(0, 60) == 0));
      end
      sent += seg_len;
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    in_valid_i    = 1'b0;
    page_number_i = '0;
    start_trace_i = 1'b0;
    recv_hold     = 0;
    frames_reg    = FramesReset;
    active_frames = frames_limit(FramesReset);
    fault_total   = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_frame_clamp();
    test_mid_trace_config();
    test_fault_count();
    test_random_traces(1580);
    wait_all_results();
    repeat (4) @(posedge clk_i);
    $display("summary: %0d references in %0d traces, %0d words checked, %0d hits, %0d evictions",
             refs_sent, traces_started, words_checked, hits_seen, evictions_seen);
    $display("summary: frame clamping, mid-trace writes, fault counting, back-pressure");
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
